// ===== rtl/core/cnnsi_pkg.sv =====
// ----------------------------------------------------------------------------
// cnnsi_pkg - shape inference shared types
// Dimension widths, layer codes, status codes, queue entry and result records.
// ----------------------------------------------------------------------------
package cnnsi_pkg;

    localparam int DIM_BITS   = 16;
    localparam int NUM_W      = DIM_BITS + 1;
    localparam int PROD_W     = 2 * DIM_BITS;
    localparam int FIELD_W    = 4;
    localparam int REG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int DCNT_W     = $clog2(NUM_W);

    localparam logic [DIM_BITS-1:0] DIM_MAX = '1;

    localparam logic [REG_W-1:0] RST_HEIGHT   = REG_W'(224);
    localparam logic [REG_W-1:0] RST_WIDTH    = REG_W'(224);
    localparam logic [REG_W-1:0] RST_CHANNELS = REG_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEIGHT   = 2'd0,
        CFG_WIDTH    = 2'd1,
        CFG_CHANNELS = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_CONV    = 3'd0,
        OP_POOL    = 3'd1,
        OP_GAP     = 3'd2,
        OP_FLATTEN = 3'd3,
        OP_FC      = 3'd4,
        OP_KEEP    = 3'd5,
        OP_PROJ    = 3'd6,
        OP_SOFTMAX = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CLASS_ERR = 2'd1,
        ST_KERNEL    = 2'd2,
        ST_FLAT_SAT  = 2'd3
    } status_t;

    typedef struct packed {
        op_t                 op;
        logic                reload;
        logic [DIM_BITS-1:0] rel_h;
        logic [DIM_BITS-1:0] rel_w;
        logic [DIM_BITS-1:0] rel_c;
        logic [FIELD_W-1:0]  kernel;
        logic [FIELD_W-1:0]  pad;
        logic [FIELD_W-1:0]  stride;
        logic [DIM_BITS-1:0] oc;
    } cmd_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [FIELD_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] in_h;
        logic [DIM_BITS-1:0] in_w;
        logic [DIM_BITS-1:0] in_c;
        logic                mult8;
        logic [DIM_BITS-1:0] out_h;
        logic [DIM_BITS-1:0] out_w;
        logic [DIM_BITS-1:0] out_c;
        status_t             status;
    } res_t;

endpackage

// ===== rtl/core/cnn_layer_shape_inference_core.sv =====
// Conv, pool and projection take their height and width from the bit-serial divider,
// height then width (conv and pool skip it when the kernel does not fit); flatten
// uses up to two registered multiplies; the other layer types need neither.
// Throughput: one request in flight at execution; a two-entry queue takes more.
// Reset (async, active low): shape registers and running shape go to 224x224x3.
// ----------------------------------------------------------------------------
// cnn_layer_shape_inference_core - CNN layer shape inference
// Propagates an NHWC shape through a stream of layer descriptors.
// ----------------------------------------------------------------------------
module cnn_layer_shape_inference_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cnnsi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cnnsi_pkg::REG_W-1:0]         cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // kernel_size[3:0], padding[7:4], stride[11:8], out_channels[27:12]
    input  logic [31:0]                         s_tdata,
    // req_type[2:0], first_layer[3]
    input  logic [3:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // layer_in_height[15:0], layer_in_width[31:16], layer_in_channels[47:32],
    // channels_multiple_of_8[48], layer_out_height[64:49],
    // layer_out_width[80:65], layer_out_channels[96:81]
    output logic [103:0]                        m_tdata,
    // status[1:0]
    output logic [1:0]                          m_tuser
);

    logic                      q_full;
    logic                      q_empty;
    logic                      q_push;
    logic                      q_pop;
    cnnsi_pkg::cmd_t           q_wdata;
    cnnsi_pkg::cmd_t           q_rdata;
    cnnsi_pkg::div_req_t       div_req;
    logic                      div_done;
    logic [cnnsi_pkg::NUM_W-1:0] div_quo;
    cnnsi_pkg::res_t           res;

    cnnsi_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_valid    (s_tvalid),
        .req_ready    (s_tready),
        .req_type     (s_tuser[2:0]),
        .first_layer  (s_tuser[3]),
        .kernel_size  (s_tdata[3:0]),
        .padding      (s_tdata[7:4]),
        .stride       (s_tdata[11:8]),
        .out_channels (s_tdata[27:12]),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_wdata      (q_wdata)
    );

    cnnsi_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .full  (q_full)
    );

    cnnsi_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo)
    );

    cnnsi_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .div_req   (div_req),
        .div_done  (div_done),
        .div_quo   (div_quo),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {7'b0, res.out_c, res.out_w, res.out_h, res.mult8,
                      res.in_c, res.in_w, res.in_h};
    assign m_tuser = res.status;

endmodule

// ===== rtl/core/cnnsi_front.sv =====
// ----------------------------------------------------------------------------
// cnnsi_front - request intake
// Holds the network input shape registers and turns each request into a
// queue entry with the reload shape attached and the stride cleaned up.
// ----------------------------------------------------------------------------
module cnnsi_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cnnsi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cnnsi_pkg::REG_W-1:0]         cfg_data,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic [2:0]                          req_type,
    input  logic                                first_layer,
    input  logic [cnnsi_pkg::FIELD_W-1:0]       kernel_size,
    input  logic [cnnsi_pkg::FIELD_W-1:0]       padding,
    input  logic [cnnsi_pkg::FIELD_W-1:0]       stride,
    input  logic [cnnsi_pkg::DIM_BITS-1:0]      out_channels,
    input  logic                                q_full,
    output logic                                q_push,
    output cnnsi_pkg::cmd_t                     q_wdata
);

    logic [cnnsi_pkg::REG_W-1:0] in_h_reg;
    logic [cnnsi_pkg::REG_W-1:0] in_w_reg;
    logic [cnnsi_pkg::REG_W-1:0] in_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_h_reg <= cnnsi_pkg::RST_HEIGHT;
            in_w_reg <= cnnsi_pkg::RST_WIDTH;
            in_c_reg <= cnnsi_pkg::RST_CHANNELS;
        end
        else if (cfg_we)
        begin
            case (cnnsi_pkg::cfg_idx_t'(cfg_index))
                cnnsi_pkg::CFG_HEIGHT:   in_h_reg <= cfg_data;
                cnnsi_pkg::CFG_WIDTH:    in_w_reg <= cfg_data;
                cnnsi_pkg::CFG_CHANNELS: in_c_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign req_ready = !q_full;
    assign q_push    = req_valid && !q_full;

    always_comb
    begin
        q_wdata.op     = cnnsi_pkg::op_t'(req_type);
        q_wdata.reload = first_layer;
        q_wdata.rel_h  = in_h_reg[cnnsi_pkg::DIM_BITS-1:0];
        q_wdata.rel_w  = in_w_reg[cnnsi_pkg::DIM_BITS-1:0];
        q_wdata.rel_c  = in_c_reg[cnnsi_pkg::DIM_BITS-1:0];
        q_wdata.kernel = kernel_size;
        q_wdata.pad    = padding;
        // zero stride behaves as one
        q_wdata.stride = (stride == '0) ? cnnsi_pkg::FIELD_W'(1) : stride;
        q_wdata.oc     = out_channels;
    end

endmodule

// ===== rtl/core/cnnsi_queue.sv =====
// ----------------------------------------------------------------------------
// cnnsi_queue - command queue
// Short register queue between intake and execution.
// ----------------------------------------------------------------------------
module cnnsi_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cnnsi_pkg::cmd_t  wdata,
    input  logic             pop,
    output cnnsi_pkg::cmd_t  rdata,
    output logic             empty,
    output logic             full
);

    cnnsi_pkg::cmd_t                   mem_reg [cnnsi_pkg::QDEPTH];
    logic [cnnsi_pkg::QPTR_W-1:0]      wptr_reg;
    logic [cnnsi_pkg::QPTR_W-1:0]      rptr_reg;
    logic [cnnsi_pkg::QCNT_W-1:0]      cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == cnnsi_pkg::QCNT_W'(cnnsi_pkg::QDEPTH));
    assign rdata = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == cnnsi_pkg::QPTR_W'(cnnsi_pkg::QDEPTH - 1))
                            ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == cnnsi_pkg::QPTR_W'(cnnsi_pkg::QDEPTH - 1))
                            ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/cnnsi_div.sv =====
// ----------------------------------------------------------------------------
// cnnsi_div - bit-serial divider
// Restoring division of a dimension numerator by the stride, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module cnnsi_div
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  cnnsi_pkg::div_req_t              req,
    output logic                             done,
    output logic [cnnsi_pkg::NUM_W-1:0]      quo
);

    logic [cnnsi_pkg::NUM_W-1:0]    num_reg;
    logic [cnnsi_pkg::NUM_W-1:0]    quo_reg;
    logic [cnnsi_pkg::FIELD_W-1:0]  den_reg;
    logic [cnnsi_pkg::FIELD_W-1:0]  rem_reg;
    logic [cnnsi_pkg::DCNT_W-1:0]   cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [cnnsi_pkg::FIELD_W:0]    trial;
    logic [cnnsi_pkg::FIELD_W:0]    diff;
    logic                           qbit;
    logic [cnnsi_pkg::FIELD_W-1:0]  rem_next;

    always_comb
    begin
        trial    = {rem_reg, num_reg[cnnsi_pkg::NUM_W-1]};
        qbit     = (trial >= {1'b0, den_reg});
        diff     = trial - {1'b0, den_reg};
        rem_next = qbit ? diff[cnnsi_pkg::FIELD_W-1:0] : trial[cnnsi_pkg::FIELD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[cnnsi_pkg::NUM_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[cnnsi_pkg::NUM_W-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= cnnsi_pkg::DCNT_W'(cnnsi_pkg::NUM_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/core/cnnsi_back.sv =====
// ----------------------------------------------------------------------------
// cnnsi_back - layer execution
// Keeps the running shape, works out each layer's output shape with the
// shared divider and a registered multiplier, and holds the result register.
// ----------------------------------------------------------------------------
module cnnsi_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    input  cnnsi_pkg::cmd_t                   q_rdata,
    output logic                              q_pop,
    output cnnsi_pkg::div_req_t               div_req,
    input  logic                              div_done,
    input  logic [cnnsi_pkg::NUM_W-1:0]       div_quo,
    output logic                              res_valid,
    input  logic                              res_ready,
    output cnnsi_pkg::res_t                   res
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_DIVH = 7'b0000100,
        S_DIVW = 7'b0001000,
        S_MULA = 7'b0010000,
        S_MULB = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    state_t                              state_reg;
    state_t                              state_next;
    cnnsi_pkg::cmd_t                     cmd_reg;
    logic [cnnsi_pkg::DIM_BITS-1:0]      cur_h_reg;
    logic [cnnsi_pkg::DIM_BITS-1:0]      cur_w_reg;
    logic [cnnsi_pkg::DIM_BITS-1:0]      cur_c_reg;
    logic [cnnsi_pkg::DIM_BITS-1:0]      h_reg;
    logic [cnnsi_pkg::DIM_BITS-1:0]      w_reg;
    logic [cnnsi_pkg::DIM_BITS-1:0]      c_reg;
    logic [cnnsi_pkg::DIM_BITS-1:0]      nh_reg;
    logic [cnnsi_pkg::DIM_BITS-1:0]      nw_reg;
    logic [cnnsi_pkg::DIM_BITS-1:0]      nc_reg;
    cnnsi_pkg::status_t                  status_reg;
    logic [cnnsi_pkg::PROD_W-1:0]        prod_reg;
    logic                                res_valid_reg;
    cnnsi_pkg::res_t                     res_reg;

    logic [cnnsi_pkg::NUM_W-1:0]         span_h;
    logic [cnnsi_pkg::NUM_W-1:0]         span_w;
    logic                                too_big;
    logic                                is_proj;
    logic [cnnsi_pkg::NUM_W-1:0]         num_h;
    logic [cnnsi_pkg::NUM_W-1:0]         num_w;
    logic [cnnsi_pkg::DIM_BITS-1:0]      div_dim;
    logic                                res_load;

    function automatic logic [cnnsi_pkg::DIM_BITS-1:0] sat_inc
        (input logic [cnnsi_pkg::NUM_W-1:0] q);
        logic [cnnsi_pkg::NUM_W:0] s;
        begin
            s = {1'b0, q} + 1'b1;
            sat_inc = (s > {2'b00, cnnsi_pkg::DIM_MAX}) ? cnnsi_pkg::DIM_MAX
                                                        : s[cnnsi_pkg::DIM_BITS-1:0];
        end
    endfunction

    always_comb
    begin
        span_h  = {1'b0, h_reg} + cnnsi_pkg::NUM_W'({cmd_reg.pad, 1'b0});
        span_w  = {1'b0, w_reg} + cnnsi_pkg::NUM_W'({cmd_reg.pad, 1'b0});
        too_big = (cnnsi_pkg::NUM_W'(cmd_reg.kernel) > span_h)
               || (cnnsi_pkg::NUM_W'(cmd_reg.kernel) > span_w);
        is_proj = (cmd_reg.op == cnnsi_pkg::OP_PROJ);
        num_h   = is_proj ? ({1'b0, h_reg} - 1'b1)
                          : (span_h - cnnsi_pkg::NUM_W'(cmd_reg.kernel));
        num_w   = is_proj ? ({1'b0, w_reg} - 1'b1)
                          : (span_w - cnnsi_pkg::NUM_W'(cmd_reg.kernel));
        div_dim = (state_reg == S_DIVH) ? h_reg : w_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        div_req.start = 1'b0;
        div_req.num   = num_h;
        div_req.den   = cmd_reg.stride;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (cmd_reg.op)
                    cnnsi_pkg::OP_CONV, cnnsi_pkg::OP_POOL:
                    begin
                        if (too_big)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            state_next    = S_DIVH;
                        end
                    end
                    cnnsi_pkg::OP_PROJ:
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_DIVH;
                    end
                    cnnsi_pkg::OP_FLATTEN: state_next = S_MULA;
                    default:               state_next = S_FIN;
                endcase
            end
            S_DIVH:
            begin
                if (div_done)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = num_w;
                    state_next    = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_MULA:
            begin
                state_next = (prod_reg[cnnsi_pkg::PROD_W-1:cnnsi_pkg::DIM_BITS] != '0)
                             ? S_FIN : S_MULB;
            end
            S_MULB:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign res_load = (state_reg == S_FIN) && (!res_valid_reg || res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            cur_h_reg     <= cnnsi_pkg::RST_HEIGHT[cnnsi_pkg::DIM_BITS-1:0];
            cur_w_reg     <= cnnsi_pkg::RST_WIDTH[cnnsi_pkg::DIM_BITS-1:0];
            cur_c_reg     <= cnnsi_pkg::RST_CHANNELS[cnnsi_pkg::DIM_BITS-1:0];
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
                cur_h_reg     <= nh_reg;
                cur_w_reg     <= nw_reg;
                cur_c_reg     <= nc_reg;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_rdata;
            h_reg   <= q_rdata.reload ? q_rdata.rel_h : cur_h_reg;
            w_reg   <= q_rdata.reload ? q_rdata.rel_w : cur_w_reg;
            c_reg   <= q_rdata.reload ? q_rdata.rel_c : cur_c_reg;
        end

        unique case (state_reg)
            S_EXEC:
            begin
                nh_reg     <= h_reg;
                nw_reg     <= w_reg;
                nc_reg     <= c_reg;
                status_reg <= cnnsi_pkg::ST_OK;
                prod_reg   <= h_reg * w_reg;
                case (cmd_reg.op)
                    cnnsi_pkg::OP_CONV:
                    begin
                        if (too_big)
                        begin
                            status_reg <= cnnsi_pkg::ST_KERNEL;
                        end
                        else
                        begin
                            nc_reg <= cmd_reg.oc;
                        end
                    end
                    cnnsi_pkg::OP_POOL:
                    begin
                        if (too_big)
                        begin
                            status_reg <= cnnsi_pkg::ST_KERNEL;
                        end
                    end
                    cnnsi_pkg::OP_GAP, cnnsi_pkg::OP_FLATTEN:
                    begin
                        nh_reg <= cnnsi_pkg::DIM_BITS'(1);
                        nw_reg <= cnnsi_pkg::DIM_BITS'(1);
                    end
                    cnnsi_pkg::OP_FC:
                    begin
                        nh_reg <= cnnsi_pkg::DIM_BITS'(1);
                        nw_reg <= cnnsi_pkg::DIM_BITS'(1);
                        nc_reg <= cmd_reg.oc;
                    end
                    cnnsi_pkg::OP_PROJ:
                    begin
                        nc_reg <= cmd_reg.oc;
                    end
                    cnnsi_pkg::OP_SOFTMAX:
                    begin
                        if (c_reg != cmd_reg.oc)
                        begin
                            status_reg <= cnnsi_pkg::ST_CLASS_ERR;
                        end
                    end
                    default: ;
                endcase
            end
            S_DIVH, S_DIVW:
            begin
                if (div_done)
                begin
                    // projection of an empty dimension stays empty
                    if (state_reg == S_DIVH)
                    begin
                        nh_reg <= (is_proj && div_dim == '0) ? '0 : sat_inc(div_quo);
                    end
                    else
                    begin
                        nw_reg <= (is_proj && div_dim == '0) ? '0 : sat_inc(div_quo);
                    end
                end
            end
            S_MULA:
            begin
                if (prod_reg[cnnsi_pkg::PROD_W-1:cnnsi_pkg::DIM_BITS] != '0)
                begin
                    nc_reg     <= cnnsi_pkg::DIM_MAX;
                    status_reg <= cnnsi_pkg::ST_FLAT_SAT;
                end
                else
                begin
                    prod_reg <= prod_reg[cnnsi_pkg::DIM_BITS-1:0] * c_reg;
                end
            end
            S_MULB:
            begin
                if (prod_reg[cnnsi_pkg::PROD_W-1:cnnsi_pkg::DIM_BITS] != '0)
                begin
                    nc_reg     <= cnnsi_pkg::DIM_MAX;
                    status_reg <= cnnsi_pkg::ST_FLAT_SAT;
                end
                else
                begin
                    nc_reg <= prod_reg[cnnsi_pkg::DIM_BITS-1:0];
                end
            end
            default: ;
        endcase

        if (res_load)
        begin
            res_reg.in_h   <= h_reg;
            res_reg.in_w   <= w_reg;
            res_reg.in_c   <= c_reg;
            res_reg.mult8  <= (c_reg[2:0] == 3'b000);
            res_reg.out_h  <= nh_reg;
            res_reg.out_w  <= nw_reg;
            res_reg.out_c  <= nc_reg;
            res_reg.status <= status_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - layer shape inference core
// Walks a short table of layer descriptors and register settings, then sends
// random layer chains under several register settings; both stream sides idle at
// random in most segments. Results are checked against table rows or a predictor.
// ----------------------------------------------------------------------------
module testbench;

    import cnnsi_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SEGMENTS    = 12;
    localparam int SEG_LAYERS  = 155;

    typedef struct {
        bit        reconfig;
        bit [15:0] cfg_h;
        bit [15:0] cfg_w;
        bit [15:0] cfg_c;
        op_t       op;
        bit        first;
        bit [3:0]  kern;
        bit [3:0]  pad;
        bit [3:0]  step;
        bit [15:0] oc;
        bit        typed;
        res_t      want;
    } plan_row_t;

    localparam res_t UNTYPED = '0;

    logic         clk;
    logic         rst_n     = 1'b0;
    logic         cfg_we    = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [15:0]  cfg_data  = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata   = '0;
    logic [3:0]   s_tuser   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [103:0] m_tdata;
    logic [1:0]   m_tuser;

    // predictor copy of the registers and running shape
    bit [15:0] reg_h = RST_HEIGHT;
    bit [15:0] reg_w = RST_WIDTH;
    bit [15:0] reg_c = RST_CHANNELS;
    bit [15:0] run_h = RST_HEIGHT;
    bit [15:0] run_w = RST_WIDTH;
    bit [15:0] run_c = RST_CHANNELS;

    res_t shapes_due [$];
    int   fail_count   = 0;
    int   results_seen = 0;
    int   cycle_count  = 0;
    int   tx_idle_pct  = 14;
    int   rx_idle_pct  = 86;
    int   rx_hold      = 0;

    plan_row_t plan [28] = '{
        '{0, 0, 0, 0, OP_KEEP, 1, 0, 0, 0, 0, 1,
          '{224, 224, 3, 0, 224, 224, 3, ST_OK}},
        '{0, 0, 0, 0, OP_SOFTMAX, 0, 0, 0, 0, 10, 1,
          '{224, 224, 3, 0, 224, 224, 3, ST_CLASS_ERR}},
        '{0, 0, 0, 0, OP_SOFTMAX, 0, 0, 0, 0, 3, 1,
          '{224, 224, 3, 0, 224, 224, 3, ST_OK}},
        '{0, 0, 0, 0, OP_CONV, 0, 3, 1, 1, 64, 1,
          '{224, 224, 3, 0, 224, 224, 64, ST_OK}},
        '{0, 0, 0, 0, OP_POOL, 0, 2, 0, 2, 0, 1,
          '{224, 224, 64, 1, 112, 112, 64, ST_OK}},
        '{0, 0, 0, 0, OP_CONV, 0, 15, 0, 15, 65535, 0, UNTYPED},
        '{0, 0, 0, 0, OP_PROJ, 0, 0, 0, 0, 0, 0, UNTYPED},
        '{0, 0, 0, 0, OP_SOFTMAX, 0, 0, 0, 0, 0, 0, UNTYPED},
        '{0, 0, 0, 0, OP_FLATTEN, 0, 0, 0, 0, 0, 0, UNTYPED},
        '{0, 0, 0, 0, OP_FC, 0, 0, 0, 0, 65535, 0, UNTYPED},
        '{0, 0, 0, 0, OP_CONV, 0, 15, 0, 1, 5, 1,
          '{1, 1, 65535, 0, 1, 1, 65535, ST_KERNEL}},
        '{0, 0, 0, 0, OP_CONV, 0, 0, 15, 1, 8, 0, UNTYPED},
        '{0, 0, 0, 0, OP_POOL, 0, 15, 15, 15, 0, 0, UNTYPED},
        '{0, 0, 0, 0, OP_GAP, 0, 0, 0, 0, 0, 0, UNTYPED},
        '{0, 0, 0, 0, OP_FLATTEN, 1, 0, 0, 0, 0, 1,
          '{224, 224, 3, 0, 1, 1, 65535, ST_FLAT_SAT}},
        '{0, 0, 0, 0, OP_PROJ, 1, 0, 0, 15, 16, 0, UNTYPED},
        '{1, 65535, 65535, 65535, OP_KEEP, 0, 0, 0, 0, 0, 0, UNTYPED},
        '{0, 0, 0, 0, OP_CONV, 1, 1, 15, 1, 65535, 1,
          '{65535, 65535, 65535, 0, 65535, 65535, 65535, ST_OK}},
        '{0, 0, 0, 0, OP_FLATTEN, 1, 0, 0, 0, 0, 1,
          '{65535, 65535, 65535, 0, 1, 1, 65535, ST_FLAT_SAT}},
        '{0, 0, 0, 0, OP_PROJ, 1, 0, 0, 15, 65535, 0, UNTYPED},
        '{1, 0, 0, 0, OP_KEEP, 0, 0, 0, 0, 0, 0, UNTYPED},
        '{0, 0, 0, 0, OP_PROJ, 1, 0, 0, 2, 7, 1,
          '{0, 0, 0, 1, 0, 0, 7, ST_OK}},
        '{0, 0, 0, 0, OP_CONV, 1, 1, 0, 1, 9, 1,
          '{0, 0, 0, 1, 0, 0, 0, ST_KERNEL}},
        '{0, 0, 0, 0, OP_POOL, 1, 2, 1, 1, 0, 0, UNTYPED},
        '{0, 0, 0, 0, OP_FLATTEN, 1, 0, 0, 0, 0, 1,
          '{0, 0, 0, 1, 1, 1, 0, ST_OK}},
        '{0, 0, 0, 0, OP_SOFTMAX, 1, 0, 0, 0, 0, 1,
          '{0, 0, 0, 1, 0, 0, 0, ST_OK}},
        '{1, 1, 1, 1, OP_KEEP, 0, 0, 0, 0, 0, 0, UNTYPED},
        '{0, 0, 0, 0, OP_SOFTMAX, 1, 0, 0, 0, 65535, 0, UNTYPED}
    };

    cnn_layer_shape_inference_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint unsigned window_dim(longint unsigned dim, longint unsigned pad,
                                                   longint unsigned kern, longint unsigned step);
        longint unsigned v;
        v = (dim + 2 * pad - kern) / step + 1;
        return (v > DIM_MAX) ? DIM_MAX : v;
    endfunction

    // advances the running shape by one layer and returns the result it gives
    function automatic res_t shape_step(op_t op, bit first, bit [3:0] kern, bit [3:0] pad,
                                        bit [3:0] step, bit [15:0] oc);
        longint unsigned h, w, c, nh, nw, nc, prod, k, p, s;
        status_t         st;
        res_t            r;
        if (first)
        begin
            run_h = reg_h;
            run_w = reg_w;
            run_c = reg_c;
        end
        k  = kern;
        p  = pad;
        s  = (step == 0) ? 1 : step;
        h  = run_h;
        w  = run_w;
        c  = run_c;
        nh = h;
        nw = w;
        nc = c;
        st = ST_OK;
        case (op)
            OP_CONV, OP_POOL:
            begin
                if (k > h + 2 * p || k > w + 2 * p)
                    st = ST_KERNEL;
                else
                begin
                    nh = window_dim(h, p, k, s);
                    nw = window_dim(w, p, k, s);
                    if (op == OP_CONV)
                        nc = oc;
                end
            end
            OP_GAP:
            begin
                nh = 1;
                nw = 1;
            end
            OP_FLATTEN:
            begin
                nh   = 1;
                nw   = 1;
                prod = h * w;
                if (prod <= DIM_MAX)
                    prod = prod * c;
                if (prod > DIM_MAX)
                begin
                    nc = DIM_MAX;
                    st = ST_FLAT_SAT;
                end
                else
                    nc = prod;
            end
            OP_FC:
            begin
                nh = 1;
                nw = 1;
                nc = oc;
            end
            OP_KEEP:
            begin
            end
            OP_PROJ:
            begin
                nh = (h == 0) ? 0 : (h - 1) / s + 1;
                nw = (w == 0) ? 0 : (w - 1) / s + 1;
                nc = oc;
            end
            default:
            begin
                if (c != oc)
                    st = ST_CLASS_ERR;
            end
        endcase
        run_h    = nh[15:0];
        run_w    = nw[15:0];
        run_c    = nc[15:0];
        r.in_h   = h[15:0];
        r.in_w   = w[15:0];
        r.in_c   = c[15:0];
        r.mult8  = (c % 8 == 0);
        r.out_h  = nh[15:0];
        r.out_w  = nw[15:0];
        r.out_c  = nc[15:0];
        r.status = st;
        return r;
    endfunction

    function automatic int tx_gap();
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        return gap;
    endfunction

    task automatic log_fault(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    task automatic send_layer(op_t op, bit first, bit [3:0] kern, bit [3:0] pad,
                              bit [3:0] step, bit [15:0] oc, bit typed, res_t want, int gap);
        res_t pred;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, oc, step, pad, kern};
        s_tuser  <= {first, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = shape_step(op, first, kern, pad, step, oc);
        shapes_due.push_back(typed ? want : pred);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (shapes_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_shape_regs(bit [15:0] h, bit [15:0] w, bit [15:0] c);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_index <= CFG_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= CFG_CHANNELS;
        cfg_data  <= c;
        @(posedge clk);
        cfg_we <= 1'b0;
        reg_h = h;
        reg_w = w;
        reg_c = c;
    endtask

    // result sink: random stalls, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                rx_hold--;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        res_t got;
        res_t want;
        if (m_tvalid && m_tready)
        begin
            got.in_h   = m_tdata[15:0];
            got.in_w   = m_tdata[31:16];
            got.in_c   = m_tdata[47:32];
            got.mult8  = m_tdata[48];
            got.out_h  = m_tdata[64:49];
            got.out_w  = m_tdata[80:65];
            got.out_c  = m_tdata[96:81];
            got.status = status_t'(m_tuser);
            if (shapes_due.size() == 0)
                log_fault($sformatf("result %0d arrived with no request pending", results_seen));
            else
            begin
                want = shapes_due.pop_front();
                if (got.in_h !== want.in_h || got.in_w !== want.in_w ||
                    got.in_c !== want.in_c || got.mult8 !== want.mult8 ||
                    got.out_h !== want.out_h || got.out_w !== want.out_w ||
                    got.out_c !== want.out_c || got.status !== want.status)
                    log_fault($sformatf({"result %0d: expected in %0d/%0d/%0d m8 %0b ",
                        "out %0d/%0d/%0d st %0d, got in %0d/%0d/%0d m8 %0b ",
                        "out %0d/%0d/%0d st %0d"}, results_seen,
                        want.in_h, want.in_w, want.in_c, want.mult8,
                        want.out_h, want.out_w, want.out_c, want.status,
                        got.in_h, got.in_w, got.in_c, got.mult8,
                        got.out_h, got.out_w, got.out_c, got.status));
            end
            results_seen++;
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        int        seg;
        int        n;
        int        sel;
        op_t       op;
        bit        first;
        bit [3:0]  kern;
        bit [3:0]  pad;
        bit [3:0]  step;
        bit [15:0] oc;
        bit [15:0] cur_c;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].reconfig)
            begin
                wait_drained();
                set_shape_regs(plan[i].cfg_h, plan[i].cfg_w, plan[i].cfg_c);
            end
            else
                send_layer(plan[i].op, plan[i].first, plan[i].kern, plan[i].pad,
                           plan[i].step, plan[i].oc, plan[i].typed, plan[i].want, tx_gap());
        end
        wait_drained();

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            tx_idle_pct = (seg < 4) ? 14 : (seg < 8) ? 86 : 0;
            rx_idle_pct = (seg < 4) ? 86 : (seg < 8) ? 14 : 0;
            case (seg % 4)
                0: set_shape_regs($urandom_range(1, 512), $urandom_range(1, 512),
                                  $urandom_range(1, 2048));
                1: set_shape_regs($urandom_range(65535), $urandom_range(65535),
                                  $urandom_range(65535));
                2:
                begin
                    if ($urandom_range(1))
                        set_shape_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
                    else
                        set_shape_regs($urandom_range(1), $urandom_range(1),
                                       $urandom_range(1));
                end
                default: set_shape_regs($urandom_range(1, 64), $urandom_range(1, 64),
                                        $urandom_range(1, 64));
            endcase
            // sink stalls for a long stretch so the input side backs up
            if (seg == 8)
                rx_hold = 400;

            for (n = 0; n < SEG_LAYERS; n++)
            begin
                first = (n == 0) || ($urandom_range(11) == 0);
                sel   = $urandom_range(99);
                kern  = $urandom_range(1, 5);
                pad   = $urandom_range(0, 2);
                step  = $urandom_range(1, 3);
                oc    = $urandom_range(1, 512);
                if (sel < 10)
                begin
                    op    = op_t'($urandom_range(7));
                    first = $urandom_range(1);
                    kern  = $urandom_range(15);
                    pad   = $urandom_range(15);
                    step  = $urandom_range(15);
                    oc    = $urandom_range(65535);
                end
                else if (sel < 40)
                    op = OP_CONV;
                else if (sel < 55)
                    op = OP_POOL;
                else if (sel < 65)
                    op = OP_PROJ;
                else if (sel < 70)
                    op = OP_GAP;
                else if (sel < 75)
                    op = OP_FLATTEN;
                else if (sel < 80)
                    op = OP_FC;
                else if (sel < 88)
                    op = OP_KEEP;
                else
                begin
                    op    = OP_SOFTMAX;
                    cur_c = first ? reg_c : run_c;
                    oc    = ($urandom_range(2) != 0) ? cur_c : 16'($urandom_range(65535));
                end
                if (sel >= 10 && $urandom_range(7) == 0)
                    oc = $urandom_range(65535);
                send_layer(op, first, kern, pad, step, oc, 1'b0, UNTYPED, tx_gap());
            end
            wait_drained();
        end

        repeat (60) @(posedge clk);
        if (fail_count == 0 && shapes_due.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
